// ===== hdl/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg
// Shared widths, controller states and the command and status bundles that
// join the controller of the linear Diophantine solver to its datapath.
// ----------------------------------------------------------------------------
package lds_pkg;

    // Operand width; the low DATA_WIDTH bits of each operand are used.
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    // Bezout coefficients stay within about 2^(DATA_WIDTH+1) in magnitude.
    localparam int COEF_W     = DATA_WIDTH + 4;
    // Scaled solutions need the full product of two magnitudes.
    localparam int ACC_W      = 2 * DATA_WIDTH;
    localparam int SOL_W      = 63;
    localparam int GCD_W      = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EUCLID_DIV,
        ST_EUCLID_UPD,
        ST_SCALE_INIT,
        ST_SCALE_DIV,
        ST_DONE
    } lds_state_t;

    typedef struct packed {
        logic load;
        logic euclid_init;
        logic scale_init;
        logic div_step;
        logic euclid_update;
        logic publish;
    } lds_cmd_t;

    typedef struct packed {
        logic r0_zero;
        logic r1_zero;
        logic div_last;
        logic out_busy;
    } lds_status_t;

endpackage

// ===== hdl/lds_in_if.sv =====
// ----------------------------------------------------------------------------
// lds_in_if
// Operand channel: coefficients and right side of one equation per word.
// ----------------------------------------------------------------------------
interface lds_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] rhs_c;

    modport source (output valid, output coef_a, output coef_b, output rhs_c,
                    input ready);
    modport sink   (input valid, input coef_a, input coef_b, input rhs_c,
                    output ready);
endinterface

// ===== hdl/lds_out_if.sv =====
// ----------------------------------------------------------------------------
// lds_out_if
// Result channel: solvability flag, particular solution and the gcd.
// ----------------------------------------------------------------------------
interface lds_out_if;
    logic        valid;
    logic        ready;
    logic        solvable;
    logic [62:0] sol_x;
    logic [62:0] sol_y;
    logic [30:0] divisor_g;

    modport source (output valid, output solvable, output sol_x, output sol_y,
                    output divisor_g, input ready);
    modport sink   (input valid, input solvable, input sol_x, input sol_y,
                    input divisor_g, output ready);
endinterface

// ===== hdl/lds_ctrl.sv =====
// ----------------------------------------------------------------------------
// lds_ctrl
// Sequencer for the Euclid steps, the scaling division and the result hand-off.
// ----------------------------------------------------------------------------
module lds_ctrl
    import lds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  lds_status_t status,
    output lds_cmd_t    cmd
);

    lds_state_t state_reg;
    lds_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.r1_zero)
                begin
                    state_next = ST_EUCLID_DIV;
                end
                else if (status.r0_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCALE_INIT;
                end
            end
            ST_EUCLID_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_EUCLID_UPD;
                end
            end
            ST_EUCLID_UPD:
            begin
                state_next = ST_CHECK;
            end
            ST_SCALE_INIT:
            begin
                state_next = ST_SCALE_DIV;
            end
            ST_SCALE_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK:
            begin
                cmd.euclid_init = !status.r1_zero;
            end
            ST_EUCLID_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EUCLID_UPD:
            begin
                cmd.euclid_update = 1'b1;
            end
            ST_SCALE_INIT:
            begin
                cmd.scale_init = 1'b1;
            end
            ST_SCALE_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.publish = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/lds_datapath.sv =====
// ----------------------------------------------------------------------------
// lds_datapath
// Remainder and Bezout registers, a shared radix-2 divider with Horner
// accumulators for quotient times coefficient, and the output register.
// ----------------------------------------------------------------------------
module lds_datapath
    import lds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lds_cmd_t              cmd,
    output lds_status_t           status,
    input  logic [DATA_WIDTH-1:0] coef_a,
    input  logic [DATA_WIDTH-1:0] coef_b,
    input  logic [DATA_WIDTH-1:0] rhs_c,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  solvable,
    output logic [SOL_W-1:0]      sol_x,
    output logic [SOL_W-1:0]      sol_y,
    output logic [GCD_W-1:0]      divisor_g
);

    // Item registers.
    logic                     a_neg_reg, b_neg_reg, c_neg_reg, c_zero_reg;
    logic [DATA_WIDTH-1:0]    c_mag_reg;
    logic [DATA_WIDTH-1:0]    r0_reg, r1_reg;
    logic signed [COEF_W-1:0] s0_reg, s1_reg, t0_reg, t1_reg;

    // Divider registers.
    logic [DATA_WIDTH-1:0]    dq_reg, rem_reg, dvs_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [COEF_W-1:0] mx_reg, my_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;

    // Output register.
    logic                     out_valid_reg;
    logic                     solvable_reg;
    logic [SOL_W-1:0]         sol_x_reg, sol_y_reg;
    logic [GCD_W-1:0]         divisor_g_reg;

    logic [DATA_WIDTH-1:0]    a_mag, b_mag, c_mag;
    logic [DATA_WIDTH:0]      rem_shift;
    logic [DATA_WIDTH:0]      rem_diff;
    logic                     q_bit;
    logic signed [ACC_W-1:0]  mx_ext, my_ext;
    logic signed [ACC_W-1:0]  acc_x_next, acc_y_next;
    logic signed [COEF_W-1:0] s_new, t_new;
    logic signed [ACC_W-1:0]  x_final, y_final;
    logic                     flip_x, flip_y;
    logic                     ok;

    assign a_mag = coef_a[DATA_WIDTH-1] ? (~coef_a + 1'b1) : coef_a;
    assign b_mag = coef_b[DATA_WIDTH-1] ? (~coef_b + 1'b1) : coef_b;
    assign c_mag = rhs_c[DATA_WIDTH-1]  ? (~rhs_c + 1'b1)  : rhs_c;

    // One restoring division step; the quotient bit also drives the Horner
    // accumulators, which build quotient times multiplicand MSB first.
    assign rem_shift = {rem_reg, dq_reg[DATA_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign q_bit     = (rem_shift >= {1'b0, dvs_reg});
    assign mx_ext    = ACC_W'(mx_reg);
    assign my_ext    = ACC_W'(my_reg);
    assign acc_x_next = (acc_x_reg <<< 1) + (q_bit ? mx_ext : '0);
    assign acc_y_next = (acc_y_reg <<< 1) + (q_bit ? my_ext : '0);

    assign s_new = s0_reg - acc_x_reg[COEF_W-1:0];
    assign t_new = t0_reg - acc_y_reg[COEF_W-1:0];

    // The scaled products carry the sign of c times the sign of the coefficient.
    assign flip_x  = c_neg_reg ^ a_neg_reg;
    assign flip_y  = c_neg_reg ^ b_neg_reg;
    assign x_final = flip_x ? -acc_x_reg : acc_x_reg;
    assign y_final = flip_y ? -acc_y_reg : acc_y_reg;
    assign ok      = status.r0_zero ? c_zero_reg : (rem_reg == '0);

    assign status.r0_zero  = (r0_reg == '0);
    assign status.r1_zero  = (r1_reg == '0);
    assign status.div_last = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_neg_reg  <= coef_a[DATA_WIDTH-1];
            b_neg_reg  <= coef_b[DATA_WIDTH-1];
            c_neg_reg  <= rhs_c[DATA_WIDTH-1];
            c_zero_reg <= (rhs_c == '0);
            c_mag_reg  <= c_mag;
            r0_reg     <= a_mag;
            r1_reg     <= b_mag;
            s0_reg     <= COEF_W'(1);
            s1_reg     <= '0;
            t0_reg     <= '0;
            t1_reg     <= COEF_W'(1);
        end
        else if (cmd.euclid_update)
        begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            s0_reg <= s1_reg;
            s1_reg <= s_new;
            t0_reg <= t1_reg;
            t1_reg <= t_new;
        end

        if (cmd.euclid_init || cmd.scale_init)
        begin
            dq_reg    <= cmd.euclid_init ? r0_reg : c_mag_reg;
            dvs_reg   <= cmd.euclid_init ? r1_reg : r0_reg;
            mx_reg    <= cmd.euclid_init ? s1_reg : s0_reg;
            my_reg    <= cmd.euclid_init ? t1_reg : t0_reg;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg    <= {dq_reg[DATA_WIDTH-2:0], q_bit};
            rem_reg   <= q_bit ? rem_diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
            cnt_reg   <= cnt_reg + 1'b1;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end

        if (cmd.publish)
        begin
            solvable_reg  <= ok;
            sol_x_reg     <= (ok && !status.r0_zero) ? SOL_W'(x_final) : '0;
            sol_y_reg     <= (ok && !status.r0_zero) ? SOL_W'(y_final) : '0;
            divisor_g_reg <= GCD_W'(r0_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign solvable  = solvable_reg;
    assign sol_x     = sol_x_reg;
    assign sol_y     = sol_y_reg;
    assign divisor_g = divisor_g_reg;

endmodule

// ===== hdl/linear_diophantine_solver.sv =====
// Each word is taken in the idle state; each Euclid step then runs a check,
// a radix-2 division and an update. A final check leads to the scaling division
// of |c| by g (skipped when a and b are both zero), then the output register is loaded.
// A word takes n Euclid steps; n is at most about 46 at 32 bits.
// One word in flight at a time; a new word is taken once the previous result is loaded.
// Reset (rst_n, asynchronous, active low) clears the controller and output valid.
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// Solves a*x + b*y = c for one particular integer solution using the extended
// Euclidean algorithm, reporting the gcd and whether a solution exists.
// ----------------------------------------------------------------------------
module linear_diophantine_solver
    import lds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lds_in_if.sink    operands,
    lds_out_if.source results
);

    // The controller sequences the work; the datapath holds every number.
    // They talk through one command bundle and one status bundle.
    lds_cmd_t    cmd;
    lds_status_t status;

    // The controller accepts a word only in its idle state. The result of the
    // previous word may still sit in the output register while the next word
    // is being worked on; the controller waits in its final state only if that
    // register is still full when the new result is ready.
    lds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operands.valid),
        .in_ready (operands.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath runs Euclid on the magnitudes of a and b with one shared
    // bit-serial divider. While the divider produces quotient bits MSB first,
    // two accumulators fold in the multiplicand for each set bit, so the
    // quotient-times-coefficient products come out with no multiplier. The
    // same divider then divides |c| by g: a zero remainder means solvable, and
    // the accumulators deliver the Bezout pair scaled by |c|/g. When a and b
    // are both zero, g is zero and the word is solvable only if c is zero.
    // Only the low DATA_WIDTH bits of each operand are significant.
    lds_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .coef_a    (operands.coef_a[DATA_WIDTH-1:0]),
        .coef_b    (operands.coef_b[DATA_WIDTH-1:0]),
        .rhs_c     (operands.rhs_c[DATA_WIDTH-1:0]),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .solvable  (results.solvable),
        .sol_x     (results.sol_x),
        .sol_y     (results.sol_y),
        .divisor_g (results.divisor_g)
    );

endmodule
